// File: design/athm_pkg.sv
// Shared types, constants and defaults for the adaptive tabu history matcher.
package athm_pkg;

    localparam int MAX_HISTORY_DEFAULT = 16;
    localparam int MAX_SLOTS_DEFAULT   = 8;
    localparam int ANGLE_BITS_DEFAULT  = 8;

    localparam int PORT_ANGLE_W = 8;
    localparam int PORT_SLOTS   = 8;
    localparam int SLOTS_W      = 4;
    localparam int TENURE_W     = 5;
    localparam int COUNT_W      = 5;
    localparam int QUIET_W      = 6;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 5;
    localparam int WIDE_W       = 7;

    localparam logic [QUIET_W-1:0]  QUIET_MAX            = 6'd63;
    localparam logic [SLOTS_W-1:0]  SLOTS_RESET          = 4'd4;
    localparam logic [TENURE_W-1:0] INITIAL_TENURE_RESET = 5'd8;
    localparam logic [TENURE_W-1:0] TENURE_FLOOR_RESET   = 5'd4;
    localparam logic [TENURE_W-1:0] TENURE_CEILING_RESET = 5'd16;
    localparam logic                ADAPTIVE_RESET       = 1'b1;

    localparam logic OP_CHECK  = 1'b0;
    localparam logic OP_RECORD = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SLOTS_IN_USE,
        CFG_INITIAL_TENURE,
        CFG_TENURE_FLOOR,
        CFG_TENURE_CEILING,
        CFG_ADAPTIVE_ENABLE
    } cfg_index_t;

    typedef struct packed {
        logic [TENURE_W-1:0] tenure_floor;
        logic [TENURE_W-1:0] tenure_ceiling;
        logic                adaptive_enable;
    } athm_cfg_t;

    typedef struct packed {
        logic                record;
        logic                hit;
        logic                load;
        logic [TENURE_W-1:0] load_value;
    } athm_cmd_t;

    typedef struct packed {
        logic [TENURE_W-1:0] tenure;
        logic [COUNT_W-1:0]  count;
    } athm_status_t;

    typedef struct packed {
        logic                is_tabu;
        logic [TENURE_W-1:0] tenure_now;
        logic [COUNT_W-1:0]  stored_count;
    } athm_result_t;

endpackage

// File: design/adaptive_tabu_history_matcher.sv
// Top level of the adaptive tabu history matcher: cell row, tenure control and output buffer.
//
// The block takes one check or record transaction per clock cycle while not stalled. Every
// history cell compares its entry against the incoming vector in the cycle of acceptance, the
// hit flags are ORed across the row, and the tenure rule and the shift of the row happen at the
// same clock edge, at which the result is also registered. A two-entry output buffer lets one
// result wait while the next transaction is accepted; the input stalls only while two results
// wait. History entries are plain registers in the cell row and need no clearing after reset.
module adaptive_tabu_history_matcher #(
    parameter int MAX_HISTORY = athm_pkg::MAX_HISTORY_DEFAULT,
    parameter int MAX_SLOTS   = athm_pkg::MAX_SLOTS_DEFAULT,
    parameter int ANGLE_BITS  = athm_pkg::ANGLE_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [athm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [athm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                operation,
    input  logic [athm_pkg::PORT_ANGLE_W-1:0]   slot_angle_0,
    input  logic [athm_pkg::PORT_ANGLE_W-1:0]   slot_angle_1,
    input  logic [athm_pkg::PORT_ANGLE_W-1:0]   slot_angle_2,
    input  logic [athm_pkg::PORT_ANGLE_W-1:0]   slot_angle_3,
    input  logic [athm_pkg::PORT_ANGLE_W-1:0]   slot_angle_4,
    input  logic [athm_pkg::PORT_ANGLE_W-1:0]   slot_angle_5,
    input  logic [athm_pkg::PORT_ANGLE_W-1:0]   slot_angle_6,
    input  logic [athm_pkg::PORT_ANGLE_W-1:0]   slot_angle_7,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                is_tabu,
    output logic [athm_pkg::TENURE_W-1:0]       tenure_now,
    output logic [athm_pkg::COUNT_W-1:0]        stored_count
);

    localparam int ENTRY_W = MAX_SLOTS * ANGLE_BITS;

    logic [athm_pkg::PORT_ANGLE_W-1:0] angle [athm_pkg::PORT_SLOTS];
    logic [ENTRY_W-1:0]                probe;
    logic [ENTRY_W-1:0]                chain [MAX_HISTORY];
    logic [MAX_HISTORY-1:0]            hits;
    logic [MAX_HISTORY-1:0]            live;
    logic [MAX_SLOTS-1:0]              slot_mask;

    logic [athm_pkg::SLOTS_W-1:0]  slots_in_use_reg;
    logic [athm_pkg::TENURE_W-1:0] tenure_floor_reg;
    logic [athm_pkg::TENURE_W-1:0] tenure_ceiling_reg;
    logic                          adaptive_enable_reg;

    athm_pkg::athm_cfg_t    cfg;
    athm_pkg::athm_cmd_t    cmd;
    athm_pkg::athm_status_t status_cur;
    athm_pkg::athm_status_t status_next;
    athm_pkg::athm_result_t result;

    logic                   accept;
    logic                   take;
    logic                   shift;
    logic                   hit;

    athm_pkg::athm_result_t out_reg;
    athm_pkg::athm_result_t out_next;
    athm_pkg::athm_result_t skid_reg;
    athm_pkg::athm_result_t skid_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   skid_valid_reg;
    logic                   skid_valid_next;

    assign angle[0] = slot_angle_0;
    assign angle[1] = slot_angle_1;
    assign angle[2] = slot_angle_2;
    assign angle[3] = slot_angle_3;
    assign angle[4] = slot_angle_4;
    assign angle[5] = slot_angle_5;
    assign angle[6] = slot_angle_6;
    assign angle[7] = slot_angle_7;

    for (genvar j = 0; j < MAX_SLOTS; j++)
    begin : g_slot
        assign probe[j*ANGLE_BITS +: ANGLE_BITS] = angle[j][ANGLE_BITS-1:0];
        assign slot_mask[j] = (j == 0) || (athm_pkg::SLOTS_W'(j) < slots_in_use_reg);
    end

    assign accept = in_valid && !in_stall;
    assign take   = out_valid_reg && !out_stall;
    assign shift  = accept && (operation == athm_pkg::OP_RECORD);
    assign hit    = |hits;

    for (genvar i = 0; i < MAX_HISTORY; i++)
    begin : g_cell
        logic [ENTRY_W-1:0] entry_in;
        if (i == 0)
        begin : g_head
            assign entry_in = probe;
        end
        else
        begin : g_body
            assign entry_in = chain[i-1];
        end

        assign live[i] = athm_pkg::WIDE_W'(status_cur.count) > athm_pkg::WIDE_W'(i);

        athm_cell #(
            .SLOTS      (MAX_SLOTS),
            .ANGLE_BITS (ANGLE_BITS)
        ) u_cell (
            .clk       (clk),
            .shift     (shift),
            .live      (live[i]),
            .slot_mask (slot_mask),
            .entry_in  (entry_in),
            .probe     (probe),
            .entry_out (chain[i]),
            .hit       (hits[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_in_use_reg    <= athm_pkg::SLOTS_RESET;
            tenure_floor_reg    <= athm_pkg::TENURE_FLOOR_RESET;
            tenure_ceiling_reg  <= athm_pkg::TENURE_CEILING_RESET;
            adaptive_enable_reg <= athm_pkg::ADAPTIVE_RESET;
        end
        else if (cfg_we)
        begin
            case (athm_pkg::cfg_index_t'(cfg_index))
                athm_pkg::CFG_SLOTS_IN_USE:    slots_in_use_reg    <= cfg_data[athm_pkg::SLOTS_W-1:0];
                athm_pkg::CFG_TENURE_FLOOR:    tenure_floor_reg    <= cfg_data;
                athm_pkg::CFG_TENURE_CEILING:  tenure_ceiling_reg  <= cfg_data;
                athm_pkg::CFG_ADAPTIVE_ENABLE: adaptive_enable_reg <= cfg_data[0];
                default:                       ;
            endcase
        end
    end

    assign cfg.tenure_floor    = tenure_floor_reg;
    assign cfg.tenure_ceiling  = tenure_ceiling_reg;
    assign cfg.adaptive_enable = adaptive_enable_reg;

    assign cmd.record     = shift;
    assign cmd.hit        = hit;
    assign cmd.load       = cfg_we &&
                            (athm_pkg::cfg_index_t'(cfg_index) == athm_pkg::CFG_INITIAL_TENURE);
    assign cmd.load_value = cfg_data;

    athm_ctrl #(
        .MAX_HISTORY (MAX_HISTORY)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (cmd),
        .status_cur  (status_cur),
        .status_next (status_next)
    );

    assign result.is_tabu      = hit;
    assign result.tenure_now   = status_next.tenure;
    assign result.stored_count = status_next.count;

    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        if (accept)
        begin
            if (!out_valid_next)
            begin
                out_next       = result;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = result;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign in_stall     = skid_valid_reg;
    assign out_valid    = out_valid_reg;
    assign is_tabu      = out_reg.is_tabu;
    assign tenure_now   = out_reg.tenure_now;
    assign stored_count = out_reg.stored_count;

endmodule

// File: design/athm_cell.sv
// One history cell: holds an entry, shifts it to the next cell and compares it to the probe.
module athm_cell #(
    parameter int SLOTS      = athm_pkg::MAX_SLOTS_DEFAULT,
    parameter int ANGLE_BITS = athm_pkg::ANGLE_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          shift,
    input  logic                          live,
    input  logic [SLOTS-1:0]              slot_mask,
    input  logic [SLOTS*ANGLE_BITS-1:0]   entry_in,
    input  logic [SLOTS*ANGLE_BITS-1:0]   probe,
    output logic [SLOTS*ANGLE_BITS-1:0]   entry_out,
    output logic                          hit
);

    logic [SLOTS*ANGLE_BITS-1:0] entry_reg;
    logic [SLOTS-1:0]            slot_equal;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            entry_reg <= entry_in;
        end
    end

    for (genvar j = 0; j < SLOTS; j++)
    begin : g_slot
        assign slot_equal[j] = !slot_mask[j] ||
            (entry_reg[j*ANGLE_BITS +: ANGLE_BITS] == probe[j*ANGLE_BITS +: ANGLE_BITS]);
    end

    assign entry_out = entry_reg;
    assign hit       = live && (&slot_equal);

endmodule

// File: design/athm_ctrl.sv
// Tenure, entry count and quiet counter with the adaptive tenure rule.
module athm_ctrl #(
    parameter int MAX_HISTORY = athm_pkg::MAX_HISTORY_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  athm_pkg::athm_cfg_t cfg,
    input  athm_pkg::athm_cmd_t cmd,
    output athm_pkg::athm_status_t status_cur,
    output athm_pkg::athm_status_t status_next
);

    localparam logic [athm_pkg::WIDE_W-1:0] MAX_HISTORY_W = athm_pkg::WIDE_W'(MAX_HISTORY);

    logic [athm_pkg::TENURE_W-1:0] tenure_reg;
    logic [athm_pkg::TENURE_W-1:0] tenure_next;
    logic [athm_pkg::COUNT_W-1:0]  count_reg;
    logic [athm_pkg::COUNT_W-1:0]  count_next;
    logic [athm_pkg::QUIET_W-1:0]  quiet_reg;
    logic [athm_pkg::QUIET_W-1:0]  quiet_next;
    logic [athm_pkg::TENURE_W-1:0] load_clamped;
    logic [athm_pkg::TENURE_W-1:0] reset_clamped;

    function automatic logic [athm_pkg::TENURE_W-1:0] clamp_tenure(
        input logic [athm_pkg::TENURE_W-1:0] value
    );
        logic [athm_pkg::TENURE_W-1:0] result;
        result = value;
        if (value == '0)
        begin
            result = athm_pkg::TENURE_W'(1);
        end
        else if (athm_pkg::WIDE_W'(value) > MAX_HISTORY_W)
        begin
            result = athm_pkg::TENURE_W'(MAX_HISTORY);
        end
        return result;
    endfunction

    assign load_clamped  = clamp_tenure(cmd.load_value);
    assign reset_clamped = clamp_tenure(athm_pkg::INITIAL_TENURE_RESET);

    always_comb
    begin
        tenure_next = tenure_reg;
        count_next  = count_reg;
        quiet_next  = quiet_reg;
        if (cmd.load)
        begin
            tenure_next = load_clamped;
            if (count_reg > load_clamped)
            begin
                count_next = load_clamped;
            end
            quiet_next = '0;
        end
        else if (cmd.record)
        begin
            if (cfg.adaptive_enable)
            begin
                if (cmd.hit)
                begin
                    if ((tenure_reg < cfg.tenure_ceiling) &&
                        (athm_pkg::WIDE_W'(tenure_reg) < MAX_HISTORY_W))
                    begin
                        tenure_next = tenure_reg + athm_pkg::TENURE_W'(1);
                    end
                    quiet_next = '0;
                end
                else
                begin
                    if (quiet_reg < athm_pkg::QUIET_MAX)
                    begin
                        quiet_next = quiet_reg + athm_pkg::QUIET_W'(1);
                    end
                    if ((quiet_next >= {tenure_reg, 1'b0}) &&
                        (tenure_reg > cfg.tenure_floor) &&
                        (tenure_reg > athm_pkg::TENURE_W'(1)))
                    begin
                        tenure_next = tenure_reg - athm_pkg::TENURE_W'(1);
                        if (count_reg > tenure_next)
                        begin
                            count_next = tenure_next;
                        end
                        quiet_next = '0;
                    end
                end
            end
            if (count_next < tenure_next)
            begin
                count_next = count_next + athm_pkg::COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tenure_reg <= reset_clamped;
            count_reg  <= '0;
            quiet_reg  <= '0;
        end
        else
        begin
            tenure_reg <= tenure_next;
            count_reg  <= count_next;
            quiet_reg  <= quiet_next;
        end
    end

    assign status_cur.tenure  = tenure_reg;
    assign status_cur.count   = count_reg;
    assign status_next.tenure = tenure_next;
    assign status_next.count  = count_next;

endmodule

// File: design/athm_checker.sv
// Port-level checks for the adaptive tabu history matcher and the bind that attaches them.
module athm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic                          is_tabu,
    input logic [athm_pkg::TENURE_W-1:0] tenure_now,
    input logic [athm_pkg::COUNT_W-1:0]  stored_count
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(is_tabu) &&
        $stable(tenure_now) && $stable(stored_count))
        else $error("Stalled result transaction changed or vanished.");

    a_count_within_tenure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> stored_count <= tenure_now)
        else $error("Stored count exceeds the tenure.");

    a_tenure_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> tenure_now != '0)
        else $error("Tenure reported as zero.");

    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("Input stalled with no result pending.");

    a_stall_releases: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && in_stall |=> !in_stall)
        else $error("Input still stalled after the waiting result was taken.");

endmodule

bind adaptive_tabu_history_matcher athm_checker u_athm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .is_tabu      (is_tabu),
    .tenure_now   (tenure_now),
    .stored_count (stored_count)
);
